// ===== sv/svm_pkg.sv =====
// Shared types, codes and helper functions for the saturating 8-bit execute block.
package svm_pkg;

  localparam int RIDX_W     = 4;   // register index, up to 16 registers
  localparam int ADDR_W     = 8;   // data memory address, up to 256 bytes
  localparam int STK_ADDR_W = 10;  // stack base plus index before range check
  localparam int EXACT_W    = 17;  // exact arithmetic result before clamping

  localparam logic [7:0] STACK_BASE_RST = 8'd56;
  localparam logic signed [EXACT_W-1:0] SAT_MAX = 17'sd127;
  localparam logic signed [EXACT_W-1:0] SAT_MIN = -17'sd128;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  typedef enum logic [3:0] {
    OP_MOV     = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_MUL     = 4'd3,
    OP_DIV     = 4'd4,
    OP_IN      = 4'd5,
    OP_OUT     = 4'd6,
    OP_SHL     = 4'd7,
    OP_SHR     = 4'd8,
    OP_INC     = 4'd9,
    OP_DEC     = 4'd10,
    OP_PUSH    = 4'd11,
    OP_POP     = 4'd12,
    OP_PRELOAD = 4'd13
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_REG  = 2'd1,
    KIND_IMM  = 2'd2,
    KIND_MEM  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DST   = 3'd1,
    ST_DIV_ZERO  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MEM,
    S_EXEC,
    S_DIV
  } state_t;

  typedef struct packed {
    logic c;
    logic o;
    logic u;
    logic z;
  } flags_t;

  typedef struct packed {
    logic              rd_en;
    logic [RIDX_W-1:0] rd_a_addr;
    logic [RIDX_W-1:0] rd_b_addr;
    logic              wr_en;
    logic [RIDX_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } rf_req_t;

  typedef struct packed {
    logic              rd_en;
    logic              rd_hit;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } dm_req_t;

  function automatic logic [7:0] sat8(input logic signed [EXACT_W-1:0] v);
    if (v > SAT_MAX) begin
      return 8'h7F;
    end else if (v < SAT_MIN) begin
      return 8'h80;
    end else begin
      return v[7:0];
    end
  endfunction

  function automatic flags_t mk_flags(input logic carry, input logic signed [EXACT_W-1:0] v);
    flags_t f;
    f.c = carry;
    f.o = (v > SAT_MAX);
    f.u = (v < SAT_MIN);
    f.z = (v == '0);
    return f;
  endfunction

endpackage

// ===== sv/svm_cmd_if.sv =====
// Instruction channel: valid/ready handshake with the decoded instruction fields.
interface svm_cmd_if;
  logic              valid;
  logic              ready;
  logic [3:0]        operation;
  logic [1:0]        dst_kind;
  logic [2:0]        dst_reg;
  logic signed [8:0] dst_imm;
  logic [1:0]        src_kind;
  logic [2:0]        src_reg;
  logic signed [8:0] src_imm;
  logic signed [8:0] in_value;
  logic [7:0]        mem_address;

  modport source (output valid, operation, dst_kind, dst_reg, dst_imm, src_kind, src_reg,
                  src_imm, in_value, mem_address, input ready);
  modport sink (input valid, operation, dst_kind, dst_reg, dst_imm, src_kind, src_reg,
                src_imm, in_value, mem_address, output ready);
endinterface

// ===== sv/svm_rsp_if.sv =====
// Result channel: valid/ready handshake with the per-instruction result fields.
interface svm_rsp_if;
  logic              valid;
  logic              ready;
  logic              out_valid;
  logic signed [7:0] out_value;
  logic [2:0]        status;
  logic signed [7:0] dest_value;
  logic              carry_flag;
  logic              overflow_flag;
  logic              underflow_flag;
  logic              zero_flag;
  logic [3:0]        stack_count;

  modport source (output valid, out_valid, out_value, status, dest_value, carry_flag,
                  overflow_flag, underflow_flag, zero_flag, stack_count, input ready);
  modport sink (input valid, out_valid, out_value, status, dest_value, carry_flag,
                overflow_flag, underflow_flag, zero_flag, stack_count, output ready);
endinterface

// ===== sv/saturating_8bit_vm_execute.sv =====
// Top level: sequencer and execute datapath of the saturating 8-bit instruction executor.
// Sequence: IDLE takes an instruction and reads its registers, MEM reads the data memory,
//   EXEC commits the result to the rsp output register; DIV with a non-zero divisor
//   first runs the 8-step shift-subtract divider. One instruction is in flight at a time:
//   the next is taken only after the last commits, and EXEC waits while rsp is stalled.
// Reset (rst, synchronous): registers, memory and flags read as zero, stack empty,
//   stack_base 56; no clearing pass, per-entry valid bits clear at once.
module saturating_8bit_vm_execute #(
  parameter int REGISTER_COUNT = 8,
  parameter int MEMORY_BYTES   = 256,
  parameter int STACK_DEPTH    = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       stack_base_we,
  input  logic [7:0] stack_base_wdata,
  svm_cmd_if.sink    cmd,
  svm_rsp_if.source  rsp
);
  import svm_pkg::*;

  localparam int SW  = $clog2(STACK_DEPTH + 1);
  localparam int RCW = RIDX_W + 1;

  // register numbers wrap modulo the register count (at most 8 subtract steps)
  function automatic logic [RIDX_W-1:0] reg_idx(input logic [2:0] v);
    logic [RCW-1:0] r;
    r = RCW'(v);
    for (int k = 0; k < 8; k++) begin
      if (r >= RCW'(REGISTER_COUNT)) begin
        r = r - RCW'(REGISTER_COUNT);
      end
    end
    return r[RIDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------- control state
  state_t state;
  state_t state_next;
  logic   accept;
  logic   commit;
  logic   div_start;
  logic   div_done;
  logic   div_have;
  logic   need_div;

  // latched instruction
  op_t               op;
  kind_t             dkind;
  kind_t             skind;
  logic [RIDX_W-1:0] dreg;
  logic signed [8:0] dimm;
  logic signed [8:0] simm;
  logic [7:0]        inv;
  logic [7:0]        maddr;

  // architectural state outside the memories
  logic [7:0]    stack_base;
  logic [SW-1:0] stk_idx;
  logic [SW-1:0] stk_idx_next;
  flags_t        flags;
  flags_t        flags_next;

  // memories
  rf_req_t    rf_req;
  dm_req_t    dm_req;
  logic [7:0] rf_d;
  logic [7:0] rf_s;
  logic [7:0] dm_data;

  // output register
  logic       out_full;
  logic       o_valid;
  logic [7:0] o_value;
  status_t    o_status;
  logic [7:0] o_dest;
  flags_t     o_flags;
  logic [3:0] o_count;

  // datapath
  logic [7:0]                src_val;
  logic signed [7:0]         dv;
  logic signed [7:0]         sv;
  logic signed [EXACT_W-1:0] de;
  logic signed [EXACT_W-1:0] prodx;
  logic signed [EXACT_W-1:0] dqx;
  logic signed [EXACT_W-1:0] exact;
  logic signed [15:0]        prod;
  logic signed [8:0]         div_q;
  logic [8:0]                usum;
  logic signed [8:0]         amt;
  logic                      amt_ok;
  logic [7:0]                sh_res;
  logic [STK_ADDR_W-1:0]     push_addr;
  logic [STK_ADDR_W-1:0]     pop_addr;
  logic [STK_ADDR_W-1:0]     rd_addr;
  logic                      stk_full;
  logic                      rf_wr;
  logic [7:0]                rf_wr_data;
  logic                      dm_wr;
  logic [STK_ADDR_W-1:0]     dm_wr_addr;
  logic [7:0]                dm_wr_data;
  logic                      flags_we;
  status_t                   status_v;
  logic                      ov;
  logic [7:0]                oval;
  logic [7:0]                sc_wide;

  assign accept = cmd.valid && cmd.ready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // IDLE takes an instruction and reads both register operands, MEM reads the data memory
  // (indirect source or pop), EXEC commits once the output slot is free (DIV after S_DIV).
  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (need_div && !div_have) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (!out_full || rsp.ready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EXEC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_have <= 1'b0;
    end else if (accept) begin
      div_have <= 1'b0;
    end else if (div_done) begin
      div_have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= op_t'(cmd.operation);
      dkind <= kind_t'(cmd.dst_kind);
      skind <= kind_t'(cmd.src_kind);
      dreg  <= reg_idx(cmd.dst_reg);
      dimm  <= cmd.dst_imm;
      simm  <= cmd.src_imm;
      inv   <= cmd.in_value[7:0];
      maddr <= cmd.mem_address;
    end
  end

  // ---------------------------------------------------------------- config and state
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_base <= STACK_BASE_RST;
    end else if (stack_base_we) begin
      stack_base <= stack_base_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stk_idx <= '0;
      flags   <= '0;
    end else if (commit) begin
      stk_idx <= stk_idx_next;
      if (flags_we) begin
        flags <= flags_next;
      end
    end
  end

  // ---------------------------------------------------------------- memories
  always_comb begin
    rf_req.rd_en     = accept;
    rf_req.rd_a_addr = reg_idx(cmd.dst_reg);
    rf_req.rd_b_addr = reg_idx(cmd.src_reg);
    rf_req.wr_en     = commit && rf_wr;
    rf_req.wr_addr   = dreg;
    rf_req.wr_data   = rf_wr_data;
  end

  svm_regfile #(
    .ENTRIES (REGISTER_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .req       (rf_req),
    .rd_a_data (rf_d),
    .rd_b_data (rf_s)
  );

  // stack grows upward from stack_base; addresses past the memory read zero
  assign push_addr = STK_ADDR_W'(stack_base) + STK_ADDR_W'(stk_idx);
  assign pop_addr  = push_addr - STK_ADDR_W'(1);
  assign stk_full  = (stk_idx == SW'(STACK_DEPTH));
  assign rd_addr   = (op == OP_POP) ? pop_addr : STK_ADDR_W'(rf_s);

  always_comb begin
    dm_req.rd_en   = (state == S_MEM);
    dm_req.rd_hit  = (rd_addr < STK_ADDR_W'(MEMORY_BYTES));
    dm_req.rd_addr = rd_addr[ADDR_W-1:0];
    dm_req.wr_en   = commit && dm_wr && (dm_wr_addr < STK_ADDR_W'(MEMORY_BYTES));
    dm_req.wr_addr = dm_wr_addr[ADDR_W-1:0];
    dm_req.wr_data = dm_wr_data;
  end

  svm_datamem #(
    .DEPTH (MEMORY_BYTES)
  ) u_datamem (
    .clk     (clk),
    .rst     (rst),
    .req     (dm_req),
    .rd_data (dm_data)
  );

  // ---------------------------------------------------------------- operands
  always_comb begin
    case (skind)
      KIND_REG: src_val = rf_s;
      KIND_IMM: src_val = simm[7:0];
      KIND_MEM: src_val = dm_data;
      default:  src_val = 8'h00;
    endcase
  end

  assign dv       = rf_d;
  assign sv       = src_val;
  assign need_div = (op == OP_DIV) && (dkind == KIND_REG) && (sv != 8'sd0);

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dv),
    .divisor  (sv),
    .done     (div_done),
    .quotient (div_q)
  );

  // exact result before clamping; overflow, underflow and zero flags are taken from it
  assign prod = dv * sv;
  assign usum = {1'b0, rf_d} + {1'b0, src_val};

  always_comb begin
    de    = EXACT_W'(dv);
    prodx = EXACT_W'(prod);
    dqx   = EXACT_W'(div_q);
    case (op)
      OP_ADD:  exact = de + EXACT_W'(sv);
      OP_SUB:  exact = de - EXACT_W'(sv);
      OP_MUL:  exact = prodx;
      OP_DIV:  exact = dqx;
      OP_INC:  exact = de + 17'sd1;
      OP_DEC:  exact = de - 17'sd1;
      default: exact = de;
    endcase
  end

  // shift amount: full signed immediate, or the signed register value
  always_comb begin
    case (skind)
      KIND_IMM: amt = simm;
      KIND_REG: amt = 9'(sv);
      default:  amt = '0;
    endcase
  end

  assign amt_ok = !amt[8] && (amt[7:3] == 5'd0);

  always_comb begin
    if (!amt_ok) begin
      sh_res = 8'h00;
    end else if (op == OP_SHL) begin
      sh_res = rf_d << amt[2:0];
    end else begin
      sh_res = rf_d >> amt[2:0];
    end
  end

  // ---------------------------------------------------------------- execute
  always_comb begin
    rf_wr        = 1'b0;
    rf_wr_data   = 8'h00;
    dm_wr        = 1'b0;
    dm_wr_addr   = push_addr;
    dm_wr_data   = rf_d;
    flags_we     = 1'b0;
    flags_next   = flags;
    stk_idx_next = stk_idx;
    status_v     = ST_OK;
    ov           = 1'b0;
    oval         = 8'h00;
    if (op == OP_OUT) begin
      ov = 1'b1;
      if (dkind == KIND_REG) begin
        oval = rf_d;
      end else if (dkind == KIND_IMM) begin
        oval = dimm[7:0];
      end
    end else if (op == OP_PRELOAD) begin
      dm_wr      = 1'b1;
      dm_wr_addr = STK_ADDR_W'(maddr);
      dm_wr_data = inv;
    end else if (op > OP_PRELOAD) begin
      // unused codes: no effect, status ok
    end else if (dkind != KIND_REG) begin
      status_v = ST_BAD_DST;
    end else begin
      case (op)
        OP_MOV: begin
          rf_wr      = 1'b1;
          rf_wr_data = src_val;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INC, OP_DEC: begin
          if (op == OP_DIV && sv == 8'sd0) begin
            status_v = ST_DIV_ZERO;
          end else begin
            rf_wr      = 1'b1;
            rf_wr_data = sat8(exact);
            flags_we   = 1'b1;
            flags_next = mk_flags((op == OP_ADD) && usum[8], exact);
          end
        end
        OP_IN: begin
          rf_wr      = 1'b1;
          rf_wr_data = inv;
        end
        OP_SHL, OP_SHR: begin
          rf_wr        = 1'b1;
          rf_wr_data   = sh_res;
          flags_we     = 1'b1;
          flags_next   = '0;
          flags_next.z = (sh_res == 8'h00);
        end
        OP_PUSH: begin
          if (stk_full) begin
            status_v = ST_OVERFLOW;
          end else begin
            dm_wr        = 1'b1;
            stk_idx_next = stk_idx + SW'(1);
          end
        end
        OP_POP: begin
          if (stk_idx == '0) begin
            status_v = ST_UNDERFLOW;
          end else begin
            rf_wr        = 1'b1;
            rf_wr_data   = dm_data;
            stk_idx_next = stk_idx - SW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sc_wide = 8'(stk_idx_next);

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (commit) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      o_valid  <= ov;
      o_value  <= oval;
      o_status <= status_v;
      o_dest   <= rf_wr ? rf_wr_data : rf_d;
      o_flags  <= flags_we ? flags_next : flags;
      o_count  <= sc_wide[3:0];
    end
  end

  assign rsp.valid          = out_full;
  assign rsp.out_valid      = o_valid;
  assign rsp.out_value      = o_value;
  assign rsp.status         = o_status;
  assign rsp.dest_value     = o_dest;
  assign rsp.carry_flag     = o_flags.c;
  assign rsp.overflow_flag  = o_flags.o;
  assign rsp.underflow_flag = o_flags.u;
  assign rsp.zero_flag      = o_flags.z;
  assign rsp.stack_count    = o_count;

endmodule

// ===== sv/svm_regfile.sv =====
// Register file: two registered read ports, one write port, per-entry valid bits.
module svm_regfile #(
  parameter int ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  svm_pkg::rf_req_t     req,
  output logic [7:0]           rd_a_data,
  output logic [7:0]           rd_b_data
);
  import svm_pkg::*;

  localparam int RW = $clog2(ENTRIES);

  logic [7:0]         mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [RW-1:0]      ra;
  logic [RW-1:0]      rb;
  logic [RW-1:0]      wa;

  assign ra = req.rd_a_addr[RW-1:0];
  assign rb = req.rd_b_addr[RW-1:0];
  assign wa = req.wr_addr[RW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_data;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a_data <= vld[ra] ? mem[ra] : 8'h00;
      rd_b_data <= vld[rb] ? mem[rb] : 8'h00;
    end
  end

endmodule

// ===== sv/svm_datamem.sv =====
// Data memory: one registered read port, one write port, per-byte valid bits.
module svm_datamem #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  svm_pkg::dm_req_t req,
  output logic [7:0]       rd_data
);
  import svm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [AW-1:0]    ra;
  logic [AW-1:0]    wa;

  assign ra = req.rd_addr[AW-1:0];
  assign wa = req.wr_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[wa] <= 1'b1;
    end
  end

  // out-of-range addresses come in with rd_hit low and read zero
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= (req.rd_hit && vld[ra]) ? mem[ra] : 8'h00;
    end
  end

endmodule

// ===== sv/svm_div.sv =====
// Iterative signed 8-bit divider, one quotient bit per cycle, truncating towards zero.
module svm_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [7:0] dividend,
  input  logic signed [7:0] divisor,
  output logic              done,
  output logic signed [8:0] quotient
);
  import svm_pkg::*;

  logic       busy;
  logic [3:0] cnt;
  logic       neg;
  logic [7:0] quo;
  logic [7:0] rem;
  logic [7:0] dvs;
  logic [8:0] trial;
  logic [8:0] diff;

  // magnitude of -128 is 128, which still fits 8 unsigned bits
  assign trial = {rem, quo[7]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd8;
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[7] ^ divisor[7];
      quo <= dividend[7] ? 8'(-dividend) : dividend;
      dvs <= divisor[7] ? 8'(-divisor) : divisor;
      rem <= '0;
    end else if (busy) begin
      if (!diff[8]) begin
        rem <= diff[7:0];
        quo <= {quo[6:0], 1'b1};
      end else begin
        rem <= trial[7:0];
        quo <= {quo[6:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ===== sv/svm_checker.sv =====
// Port-level checks for the executor, attached to the top level by bind.
module svm_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       out_valid,
  input logic [7:0] out_value,
  input logic [2:0] status,
  input logic [7:0] dest_value,
  input logic [3:0] flags,
  input logic [3:0] stack_count
);
  import svm_pkg::*;

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // one instruction at a time: no transaction in the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !rst && cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("instruction taken while another is in flight");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable({out_valid, out_value, status, dest_value, flags, stack_count}))
    else $error("stalled result changed");

  // only out emits a value
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_valid |-> out_value == 8'h00)
    else $error("value emitted without out");

  // out never fails
  a_out_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_valid |-> status == ST_OK)
    else $error("out reported an error status");

endmodule

bind saturating_8bit_vm_execute svm_checker u_svm_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .out_valid   (rsp.out_valid),
  .out_value   (rsp.out_value),
  .status      (rsp.status),
  .dest_value  (rsp.dest_value),
  .flags       ({rsp.carry_flag, rsp.overflow_flag, rsp.underflow_flag, rsp.zero_flag}),
  .stack_count (rsp.stack_count)
);

// ===== verif/saturating_8bit_vm_execute_tb.sv =====
// Self-checking testbench for the saturating 8-bit instruction executor.
`timescale 1ns / 1ps

module saturating_8bit_vm_execute_tb;
  import svm_pkg::*;

  // Spare opcodes: accepted, no effect, status ok
  localparam logic [3:0] OP_SPARE_A = 4'd14;
  localparam logic [3:0] OP_SPARE_B = 4'd15;

  localparam int STACK_SLOTS = 8;
  localparam int MEM_BYTES   = 256;
  localparam int CFG_SETTLE  = 16;      // quiet cycles before a stack_base write
  localparam int CYCLE_LIMIT = 200000;  // cycle bound for the watchdog on total run length
  localparam int ITEMS_PER_PHASE = 105;

  // One decoded instruction as driven onto the command channel
  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        dk;
    logic [2:0]        dr;
    logic signed [8:0] di;
    logic [1:0]        sk;
    logic [2:0]        sr;
    logic signed [8:0] si;
    logic signed [8:0] iv;
    logic [7:0]        ma;
  } instr_t;

  // One result transaction as seen on the response channel
  typedef struct packed {
    logic              ov;
    logic signed [7:0] oval;
    logic [2:0]        st;
    logic signed [7:0] dv;
    logic              c;
    logic              o;
    logic              u;
    logic              z;
    logic [3:0]        cnt;
  } result_t;

  logic       clk;
  logic       rst;
  logic       stack_base_we;
  logic [7:0] stack_base_wdata;

  svm_cmd_if cmd();
  svm_rsp_if rsp();

  saturating_8bit_vm_execute uut (
    .clk              (clk),
    .rst              (rst),
    .stack_base_we    (stack_base_we),
    .stack_base_wdata (stack_base_wdata),
    .cmd              (cmd),
    .rsp              (rsp)
  );

  // ---------------------------------------------------------------------------
  // Machine state as the testbench sees it; updated when a command transaction
  // is accepted, so results are predicted strictly in acceptance order.
  // ---------------------------------------------------------------------------
  logic [7:0] model_regs [8];
  logic [7:0] model_mem  [MEM_BYTES];
  flags_t     model_flags;
  int         model_depth;
  logic [7:0] model_base;

  result_t pending_results [$];  // predicted results, oldest first
  int      items_sent;
  int      fault_count;
  bit      calm;                 // set for the final phase: no idling on either side

  // Directed script. Field order: op, dst kind, dst reg, dst imm, src kind, src reg,
  // src imm, in value, preload address.
  instr_t directed_script [27] = '{
    '{OP_OUT,     KIND_REG,  3'd0, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_POP,     KIND_REG,  3'd0, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_IN,      KIND_REG,  3'd1, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd127,  8'd0},
    '{OP_ADD,     KIND_REG,  3'd1, 9'sd0,   KIND_IMM,  3'd0, 9'sd1,   9'sd0,    8'd0},
    '{OP_MOV,     KIND_NONE, 3'd1, 9'sd0,   KIND_IMM,  3'd0, 9'sd5,   9'sd0,    8'd0},
    '{OP_IN,      KIND_REG,  3'd2, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   -9'sd128, 8'd0},
    '{OP_SUB,     KIND_REG,  3'd2, 9'sd0,   KIND_IMM,  3'd0, 9'sd1,   9'sd0,    8'd0},
    '{OP_MUL,     KIND_REG,  3'd1, 9'sd0,   KIND_REG,  3'd2, 9'sd0,   9'sd0,    8'd0},
    '{OP_DEC,     KIND_REG,  3'd1, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_DIV,     KIND_REG,  3'd2, 9'sd0,   KIND_IMM,  3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_IN,      KIND_REG,  3'd3, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   -9'sd1,   8'd0},
    '{OP_DIV,     KIND_REG,  3'd2, 9'sd0,   KIND_REG,  3'd3, 9'sd0,   9'sd0,    8'd0},
    '{OP_ADD,     KIND_REG,  3'd3, 9'sd0,   KIND_IMM,  3'd0, -9'sd1,  9'sd0,    8'd0},
    '{OP_SHL,     KIND_REG,  3'd1, 9'sd0,   KIND_IMM,  3'd0, 9'sd3,   9'sd0,    8'd0},
    '{OP_SHR,     KIND_REG,  3'd3, 9'sd0,   KIND_IMM,  3'd0, 9'sd255, 9'sd0,    8'd0},
    '{OP_SHL,     KIND_REG,  3'd2, 9'sd0,   KIND_IMM,  3'd0, -9'sd1,  9'sd0,    8'd0},
    '{OP_INC,     KIND_REG,  3'd2, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_DEC,     KIND_REG,  3'd3, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_PUSH,    KIND_REG,  3'd2, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_PRELOAD, KIND_NONE, 3'd7, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd90,   8'd255},
    '{OP_IN,      KIND_REG,  3'd4, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd255,  8'd0},
    '{OP_MOV,     KIND_REG,  3'd5, 9'sd0,   KIND_MEM,  3'd4, 9'sd0,   9'sd0,    8'd0},
    '{OP_POP,     KIND_REG,  3'd6, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_OUT,     KIND_IMM,  3'd0, 9'sd255, KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_OUT,     KIND_MEM,  3'd0, 9'sd0,   KIND_NONE, 3'd0, 9'sd0,   9'sd0,    8'd0},
    '{OP_SPARE_A, KIND_REG,  3'd5, 9'sd0,   KIND_REG,  3'd1, 9'sd0,   9'sd0,    8'd0},
    '{OP_SPARE_B, KIND_NONE, 3'd6, 9'sd0,   KIND_IMM,  3'd2, 9'sd7,   9'sd0,    8'd0}
  };

  // Results of the opening rows, written out by hand (state straight after reset).
  // Field order: out valid, out value, status, dest, c, o, u, z, stack count.
  result_t preset_results [5] = '{
    '{1'b1, 8'sd0, ST_OK,        8'sd0,   1'b0, 1'b0, 1'b0, 1'b0, 4'd0},  // out r0
    '{1'b0, 8'sd0, ST_UNDERFLOW, 8'sd0,   1'b0, 1'b0, 1'b0, 1'b0, 4'd0},  // pop, empty
    '{1'b0, 8'sd0, ST_OK,        8'sd127, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0},  // in 127
    '{1'b0, 8'sd0, ST_OK,        8'sd127, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0},  // 127+1 clamps
    '{1'b0, 8'sd0, ST_BAD_DST,   8'sd127, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0}   // no dest
  };

  // Flags are taken from the exact (unclamped) result
  function automatic flags_t flags_from(input logic carry, input int exact);
    flags_t f;
    f.c = carry;
    f.o = (exact > 127);
    f.u = (exact < -128);
    f.z = (exact == 0);
    return f;
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v > 127) return 8'h7F;
    if (v < -128) return 8'h80;
    return v[7:0];
  endfunction

  // Applies one accepted instruction to the machine state and returns its result
  function automatic result_t run_instruction(input instr_t x);
    result_t r;
    int      dst_s;
    int      src_s;
    int      exact;
    int      amt;
    int      slot;
    logic    carry;
    logic [7:0] shifted;
    r = '0;
    dst_s = $signed(model_regs[x.dr]);
    case (x.sk)
      KIND_REG: src_s = $signed(model_regs[x.sr]);
      KIND_IMM: src_s = $signed(x.si[7:0]);
      KIND_MEM: src_s = $signed(model_mem[model_regs[x.sr]]);
      default:  src_s = 0;
    endcase

    if (x.op == OP_OUT) begin
      // memory or none operand still emits, with value zero
      r.ov = 1'b1;
      if (x.dk == KIND_REG) r.oval = model_regs[x.dr];
      else if (x.dk == KIND_IMM) r.oval = x.di[7:0];
    end else if (x.op == OP_PRELOAD) begin
      model_mem[x.ma] = x.iv[7:0];
    end else if (x.op == OP_SPARE_A || x.op == OP_SPARE_B) begin
      // no effect at all
    end else if (x.dk != KIND_REG) begin
      r.st = ST_BAD_DST;
    end else begin
      case (x.op)
        OP_MOV: model_regs[x.dr] = src_s[7:0];
        OP_IN:  model_regs[x.dr] = x.iv[7:0];
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (x.op == OP_DIV && src_s == 0) begin
            r.st = ST_DIV_ZERO;
          end else begin
            carry = 1'b0;
            case (x.op)
              OP_ADD: begin
                exact = dst_s + src_s;
                carry = (int'(model_regs[x.dr]) + int'(src_s[7:0])) > 255;
              end
              OP_SUB:  exact = dst_s - src_s;
              OP_MUL:  exact = dst_s * src_s;
              default: exact = dst_s / src_s;  // truncates toward zero
            endcase
            model_flags = flags_from(carry, exact);
            model_regs[x.dr] = clamp_byte(exact);
          end
        end
        OP_SHL, OP_SHR: begin
          // full 9-bit immediate counts as the amount, so 255 clears
          amt = (x.sk == KIND_IMM) ? int'(x.si) : (x.sk == KIND_REG) ? src_s : 0;
          if (amt < 0 || amt > 7) shifted = '0;
          else if (x.op == OP_SHL) shifted = model_regs[x.dr] << amt;
          else shifted = model_regs[x.dr] >> amt;
          model_regs[x.dr] = shifted;
          model_flags = flags_from(1'b0, $signed(shifted));
        end
        OP_INC, OP_DEC: begin
          exact = (x.op == OP_INC) ? dst_s + 1 : dst_s - 1;
          model_flags = flags_from(1'b0, exact);
          model_regs[x.dr] = clamp_byte(exact);
        end
        OP_PUSH: begin
          if (model_depth >= STACK_SLOTS) begin
            r.st = ST_OVERFLOW;
          end else begin
            slot = int'(model_base) + model_depth;
            if (slot < MEM_BYTES) model_mem[slot] = model_regs[x.dr];
            model_depth++;
          end
        end
        OP_POP: begin
          if (model_depth == 0) begin
            r.st = ST_UNDERFLOW;
          end else begin
            model_depth--;
            slot = int'(model_base) + model_depth;
            model_regs[x.dr] = (slot < MEM_BYTES) ? model_mem[slot] : 8'h00;
          end
        end
        default: begin
        end
      endcase
    end

    r.dv  = model_regs[x.dr];
    r.c   = model_flags.c;
    r.o   = model_flags.o;
    r.u   = model_flags.u;
    r.z   = model_flags.z;
    r.cnt = 4'(model_depth);
    return r;
  endfunction

  // Immediates span -128..255 of the 9-bit field
  function automatic logic signed [8:0] pick_imm9();
    return 9'($urandom_range(0, 383) - 128);
  endfunction

  function automatic instr_t noise_instr();
    instr_t x;
    x.op = 4'($urandom_range(0, 15));
    x.dk = 2'($urandom_range(0, 3));
    x.dr = 3'($urandom_range(0, 7));
    x.di = pick_imm9();
    x.sk = 2'($urandom_range(0, 3));
    x.sr = 3'($urandom_range(0, 7));
    x.si = pick_imm9();
    x.iv = pick_imm9();
    x.ma = 8'($urandom_range(0, 255));
    return x;
  endfunction

  // Well-formed register operation with random operands
  function automatic instr_t alu_instr();
    instr_t x;
    x = noise_instr();
    x.dk = KIND_REG;
    do x.op = 4'($urandom_range(0, 12)); while (x.op == OP_OUT);
    // keep most shift amounts in the interesting band -1..8
    if ((x.op == OP_SHL || x.op == OP_SHR) && $urandom_range(0, 3) != 0) begin
      x.sk = KIND_IMM;
      x.si = 9'(int'($urandom_range(0, 9)) - 1);
    end
    return x;
  endfunction

  // Offers one instruction, waits for the command transaction, records the
  // expected result. valid is left high; the caller's next action lowers it or drives the next instruction.
  task automatic send(input instr_t x, input bit preset, input result_t preset_value);
    result_t predicted;
    int      gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.operation   <= x.op;
    cmd.dst_kind    <= x.dk;
    cmd.dst_reg     <= x.dr;
    cmd.dst_imm     <= x.di;
    cmd.src_kind    <= x.sk;
    cmd.src_reg     <= x.sr;
    cmd.src_imm     <= x.si;
    cmd.in_value    <= x.iv;
    cmd.mem_address <= x.ma;
    do @(posedge clk); while (!cmd.ready);
    predicted = run_instruction(x);
    pending_results.push_back(preset ? preset_value : predicted);
    items_sent++;
  endtask

  // stack_base may only change with the block idle: drain, settle, write
  task automatic write_stack_base(input logic [7:0] v);
    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    stack_base_we    <= 1'b1;
    stack_base_wdata <= v;
    @(posedge clk);
    stack_base_we <= 1'b0;
    model_base = v;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: compares every result transaction with the oldest prediction
  // and throttles ready. One long hold-off part-way through backs the block up
  // so the command side sees ready held low.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    result_t got;
    result_t want;
    int      hold_left;
    int      taken;
    bit      squeezed;
    hold_left = 0;
    taken     = 0;
    squeezed  = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got = '{rsp.out_valid, rsp.out_value, rsp.status, rsp.dest_value, rsp.carry_flag,
                rsp.overflow_flag, rsp.underflow_flag, rsp.zero_flag, rsp.stack_count};
        if (pending_results.size() == 0) begin
          if (fault_count < 10)
            $display("[%0t] result transaction with nothing outstanding", $realtime);
          fault_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.ov !== want.ov || got.oval !== want.oval || got.st !== want.st ||
              got.dv !== want.dv || got.c !== want.c || got.o !== want.o ||
              got.u !== want.u || got.z !== want.z || got.cnt !== want.cnt) begin
            if (fault_count < 10) begin
              $display("[%0t] result %0d: got ov=%0b val=%0d st=%0d dv=%0d couz=%b%b%b%b n=%0d",
                       $realtime, taken, got.ov, got.oval, got.st, got.dv,
                       got.c, got.o, got.u, got.z, got.cnt);
              $display("      expected ov=%0b val=%0d st=%0d dv=%0d couz=%b%b%b%b n=%0d",
                       want.ov, want.oval, want.st, want.dv,
                       want.c, want.o, want.u, want.z, want.cnt);
            end
            fault_count++;
          end
        end
        taken++;
      end

      // ready for the next edge: long hold, short random bursts, or open
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (taken == 150 && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = 119;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side: directed script, then five random phases at different
  // stack bases (low extreme, high extreme, two random, reset value).
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    instr_t     x;
    logic [7:0] base;
    int         target;
    int         n;
    int         a;

    rst              <= 1'b1;
    stack_base_we    <= 1'b0;
    stack_base_wdata <= '0;
    cmd.valid        <= 1'b0;
    cmd.operation    <= '0;
    cmd.dst_kind     <= '0;
    cmd.dst_reg      <= '0;
    cmd.dst_imm      <= '0;
    cmd.src_kind     <= '0;
    cmd.src_reg      <= '0;
    cmd.src_imm      <= '0;
    cmd.in_value     <= '0;
    cmd.mem_address  <= '0;

    foreach (model_regs[i]) model_regs[i] = '0;
    foreach (model_mem[i])  model_mem[i]  = '0;
    model_flags = '0;
    model_depth = 0;
    model_base  = STACK_BASE_RST;
    items_sent  = 0;
    fault_count = 0;
    calm        = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturation both ways, carry, divide by zero, -128 / -1,
    // out-of-range and negative shifts, pop on empty, memory operand, spare codes
    for (int i = 0; i < $size(directed_script); i++) begin
      if (i < $size(preset_results)) send(directed_script[i], 1'b1, preset_results[i]);
      else send(directed_script[i], 1'b0, '0);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       base = 8'd0;
        1:       base = 8'd248;
        4:       base = STACK_BASE_RST;
        default: base = 8'($urandom_range(0, 248));
      endcase
      write_stack_base(base);
      calm   = (p == 4);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send(alu_instr(), 1'b0, '0);
          6: begin
            // push run long enough to overflow at times, then drain past empty
            n = $urandom_range(1, 10);
            repeat (n) begin
              x = noise_instr();
              x.op = OP_PUSH;
              x.dk = KIND_REG;
              send(x, 1'b0, '0);
            end
            n = $urandom_range(1, 10);
            repeat (n) begin
              x = noise_instr();
              x.op = OP_POP;
              x.dk = KIND_REG;
              send(x, 1'b0, '0);
            end
          end
          7: begin
            // preload a byte, point a register at it, read it back indirectly
            x = noise_instr();
            x.op = OP_PRELOAD;
            send(x, 1'b0, '0);
            a = $urandom_range(0, 7);
            x.op = OP_IN;
            x.dk = KIND_REG;
            x.dr = 3'(a);
            x.iv = {1'b0, x.ma};
            send(x, 1'b0, '0);
            x = noise_instr();
            x.op = OP_MOV;
            x.dk = KIND_REG;
            x.sk = KIND_MEM;
            x.sr = 3'(a);
            send(x, 1'b0, '0);
          end
          8: begin
            x = noise_instr();
            x.op = OP_OUT;
            send(x, 1'b0, '0);
          end
          default: send(noise_instr(), 1'b0, '0);
        endcase
      end
    end

    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== saturating_8bit_vm_execute.f =====
sv/svm_pkg.sv
sv/svm_cmd_if.sv
sv/svm_rsp_if.sv
sv/svm_regfile.sv
sv/svm_datamem.sv
sv/svm_div.sv
sv/saturating_8bit_vm_execute.sv
sv/svm_checker.sv
verif/saturating_8bit_vm_execute_tb.sv
